/* hdl/top_k_score_insert_unit_macros.svh */
// Assertion helpers used by the checked module.
`ifndef TOP_K_SCORE_INSERT_UNIT_MACROS_SVH
`define TOP_K_SCORE_INSERT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, held off during reset.
`define TKSI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("top_k_score_insert_unit: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, held off during reset.
`define TKSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("top_k_score_insert_unit: next-cycle check failed");

`endif

/* hdl/tksi_pkg.sv */
package tksi_pkg;

    localparam int SCORE_W        = 32;
    localparam int CFG_W          = 4;
    localparam int RANK_W         = 3;
    localparam int COUNT_W        = 4;
    localparam int LIST_DEPTH_DEF = 8;

    localparam logic [CFG_W-1:0] MAX_KEPT_RST = 4'd8;

    // Data handed from one cell to its right-hand neighbor.
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      ge;
    } t_link;

    // Per-cell control from the list controller.
    typedef struct packed {
        logic upd;   // accepted beat: insert or shift this cycle
        logic vld;   // cell lies below the effective entry count
    } t_cell_ctl;

endpackage

/* hdl/top_k_score_insert_unit.sv */
// Top-K score list. Keeps up to max_kept signed Q16.16 scores, best first, in a
// row of LIST_DEPTH cells. Each input beat carries a score and a start_new flag
// that empties the list before the score is considered. The score is placed
// after every held entry with an equal or higher score; on a full list it is
// taken only when strictly above the lowest entry, which is then dropped.
// Every input beat yields exactly one result beat (accepted, rank, evicted,
// count). Throughput is one beat per clock: all cells compare the candidate in
// parallel and shift or load in the same edge that accepts the beat, and the
// result is loaded into an output register at that edge. The input side keeps
// taking beats while a result waits, as long as the output register is
// emptied in the same cycle. max_kept of zero acts as one, values above
// LIST_DEPTH act as LIST_DEPTH; lowering it trims the lowest entries silently
// at the next beat. Write max_kept only while no beat is in flight.
`include "top_k_score_insert_unit_macros.svh"

module top_k_score_insert_unit #(
    parameter int LIST_DEPTH = tksi_pkg::LIST_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // candidate input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_start_new,
    input  logic signed [tksi_pkg::SCORE_W-1:0] i_score,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_accepted,
    output logic [tksi_pkg::RANK_W-1:0]         o_rank,
    output logic                                o_evicted,
    output logic [tksi_pkg::COUNT_W-1:0]        o_count,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tksi_pkg::CFG_W-1:0]          i_cfg_max_kept
);

    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int LW  = (CW > tksi_pkg::CFG_W) ? CW : tksi_pkg::CFG_W;
    localparam int IW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int RW  = (IW > tksi_pkg::RANK_W) ? IW : tksi_pkg::RANK_W;
    localparam int CTW = (LW > tksi_pkg::COUNT_W) ? LW : tksi_pkg::COUNT_W;

    // Control and configuration registers.
    logic [tksi_pkg::CFG_W-1:0] r_max_kept;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;

    // Output register.
    logic                        r_out_valid;
    logic                        r_accepted;
    logic [tksi_pkg::RANK_W-1:0] r_rank;
    logic                        r_evicted;
    logic [tksi_pkg::COUNT_W-1:0] r_count_out;

    logic in_fire;
    logic cfg_fire;

    logic [LW-1:0] lim;
    logic [LW-1:0] eff;
    logic [LW-1:0] newcount;
    logic          full;
    logic          n_acc;
    logic [RW-1:0] rank_enc;
    logic          b_inside;

    logic [LIST_DEPTH-1:0] bnd;

    tksi_pkg::t_link     links [LIST_DEPTH];
    tksi_pkg::t_link     lefts [LIST_DEPTH];
    tksi_pkg::t_cell_ctl ctls  [LIST_DEPTH];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    // Clamp the limit, trim the count, and work out the effective length.
    always_comb begin
        if (LW'(r_max_kept) == '0) begin
            lim = LW'(1);
        end else if (LW'(r_max_kept) > LW'(LIST_DEPTH)) begin
            lim = LW'(LIST_DEPTH);
        end else begin
            lim = LW'(r_max_kept);
        end
        if (i_start_new) begin
            eff = '0;
        end else if (LW'(r_count) > lim) begin
            eff = lim;
        end else begin
            eff = LW'(r_count);
        end
        full = (eff >= lim);
    end

    // Cell row: each cell compares against the candidate and shifts right.
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign lefts[g].score = i_score;
            assign lefts[g].ge    = 1'b1;
        end else begin : g_body
            assign lefts[g] = links[g-1];
        end
        assign ctls[g].upd = in_fire && n_acc;
        assign ctls[g].vld = (LW'(g) < eff);
        assign bnd[g]      = !links[g].ge && lefts[g].ge;

        tksi_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctls[g]),
            .i_new_score (i_score),
            .i_left      (lefts[g]),
            .o_link      (links[g])
        );
    end

    // Decide acceptance and encode the insertion point from the one-hot boundary.
    always_comb begin
        rank_enc = '0;
        b_inside = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (bnd[i]) begin
                rank_enc = rank_enc | RW'(i);
            end
            if (bnd[i] && (LW'(i) < eff)) begin
                b_inside = 1'b1;
            end
        end
        n_acc    = (eff == '0) || !full || b_inside;
        newcount = full ? lim : (eff + LW'(1));
        n_count  = n_acc ? CW'(newcount) : CW'(eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_kept  <= tksi_pkg::MAX_KEPT_RST;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_fire) begin
                r_max_kept <= i_cfg_max_kept;
            end
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on every input beat taken by the handshake, accepted or not.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_accepted  <= n_acc;
            r_rank      <= n_acc ? rank_enc[tksi_pkg::RANK_W-1:0] : '0;
            r_evicted   <= n_acc && full;
            r_count_out <= CTW'(n_count) == '0 ? '0 : tksi_pkg::COUNT_W'(CTW'(n_count));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_rank      = r_rank;
    assign o_evicted   = r_evicted;
    assign o_count     = r_count_out;

    // A rejected result carries no rank and no eviction.
    `TKSI_ASSERT_SAME(a_reject_clean, i_clk, i_rst_n, o_out_valid && !o_accepted, (o_rank == '0) && !o_evicted)
    // An eviction only happens on an accepted score.
    `TKSI_ASSERT_SAME(a_evict_accepted, i_clk, i_rst_n, o_out_valid && o_evicted, o_accepted)
    // The held count never exceeds the cell row.
    `TKSI_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, LW'(r_count) <= LW'(LIST_DEPTH))
    // An eviction leaves the list exactly at the limit.
    `TKSI_ASSERT_NEXT(a_evict_full, i_clk, i_rst_n, in_fire && n_acc && full, LW'(r_count) == $past(lim))
    // Any accepted score leaves at least one entry held.
    `TKSI_ASSERT_NEXT(a_accept_nonempty, i_clk, i_rst_n, in_fire && n_acc, r_count != '0)

endmodule

/* hdl/tksi_cell.sv */
module tksi_cell (
    input  logic                                i_clk,
    input  tksi_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [tksi_pkg::SCORE_W-1:0] i_new_score,
    input  tksi_pkg::t_link                     i_left,
    output tksi_pkg::t_link                     o_link
);

    logic signed [tksi_pkg::SCORE_W-1:0] r_score;
    logic signed [tksi_pkg::SCORE_W-1:0] n_score;
    logic                                ge;

    // Held score ranks at or above the candidate: candidate goes further right.
    assign ge = i_ctl.vld && (r_score >= i_new_score);

    always_comb begin
        n_score = r_score;
        if (i_ctl.upd && !ge) begin
            if (i_left.ge) begin
                n_score = i_new_score;
            end else begin
                n_score = i_left.score;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_score <= n_score;
    end

    assign o_link.score = r_score;
    assign o_link.ge    = ge;

endmodule

/* sim/top_k_score_insert_checker.sv */
module top_k_score_insert_checker #(
    parameter int LIST_DEPTH = tksi_pkg::LIST_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_start_new,
    input  logic signed [tksi_pkg::SCORE_W-1:0] i_score,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_accepted,
    input  logic [tksi_pkg::RANK_W-1:0]         i_rank,
    input  logic                                i_evicted,
    input  logic [tksi_pkg::COUNT_W-1:0]        i_count,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [tksi_pkg::CFG_W-1:0]          i_cfg_max_kept,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import tksi_pkg::*;

    typedef struct packed {
        logic               accepted;
        logic [RANK_W-1:0]  rank;
        logic               evicted;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    logic signed [SCORE_W-1:0] kept_scores [LIST_DEPTH];
    int                        held_count;
    logic [CFG_W-1:0]          kept_limit;
    t_outcome                  outcome_q [$];

    // Insert one candidate into the shadow list and return what the block should report.
    function automatic t_outcome insert_candidate(input logic sn,
                                                  input logic signed [SCORE_W-1:0] sc);
        t_outcome res;
        int       lim;
        int       slot;
        int       grown;
        logic     full;
        res = '0;
        lim = (kept_limit == '0) ? 1 : int'(kept_limit);
        if (lim > LIST_DEPTH) lim = LIST_DEPTH;
        if (sn) held_count = 0;
        // trim silently when the limit dropped below the fill level
        if (held_count > lim) held_count = lim;
        slot = 0;
        while (slot < held_count && kept_scores[slot] >= sc) slot++;
        full = (held_count >= lim);
        if (held_count == 0 || !(full && slot >= held_count)) begin
            res.accepted = 1'b1;
            res.rank     = slot[RANK_W-1:0];
            res.evicted  = full;
            grown        = full ? lim : held_count + 1;
            for (int k = grown - 1; k > slot; k--) kept_scores[k] = kept_scores[k-1];
            kept_scores[slot] = sc;
            held_count = grown;
        end
        res.count = held_count[COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome seen;
        if (!i_rst_n) begin
            held_count = 0;
            kept_limit = MAX_KEPT_RST;
            outcome_q.delete();
        end else begin
            // compare first: a result beat always belongs to an earlier candidate
            if (i_out_valid && i_out_ready) begin
                seen = '{i_accepted, i_rank, i_evicted, i_count};
                if (outcome_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %p", $time, seen);
                    o_fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (seen.accepted !== want.accepted) begin
                        $display("%0t: accepted expected %0b got %0b",
                                 $time, want.accepted, seen.accepted);
                        o_fail_count++;
                    end
                    if (seen.rank !== want.rank) begin
                        $display("%0t: rank expected %0d got %0d", $time, want.rank, seen.rank);
                        o_fail_count++;
                    end
                    if (seen.evicted !== want.evicted) begin
                        $display("%0t: evicted expected %0b got %0b",
                                 $time, want.evicted, seen.evicted);
                        o_fail_count++;
                    end
                    if (seen.count !== want.count) begin
                        $display("%0t: count expected %0d got %0d",
                                 $time, want.count, seen.count);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) kept_limit = i_cfg_max_kept;
            if (i_in_valid && i_in_ready)
                outcome_q.push_back(insert_candidate(i_start_new, i_score));
        end
        o_pending = outcome_q.size();
    end

endmodule

/* sim/top_k_score_insert_unit_tb.sv */
module top_k_score_insert_unit_tb;
    import tksi_pkg::*;

    // Idle shapes for the two channels.
    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_SINK,
        IDLE_BOTH
    } t_idle_mode;

    localparam int HEAVY_IDLE_PCT = 84;
    localparam int BOTH_IDLE_PCT  = 38;
    localparam int RESET_CYCLES   = 12;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 94;
    localparam int TAIL_CYCLES    = 8;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      i_start_new    = 1'b0;
    logic signed [SCORE_W-1:0] i_score        = '0;
    logic                      i_out_ready    = 1'b0;
    logic                      i_cfg_valid    = 1'b0;
    logic [CFG_W-1:0]          i_cfg_max_kept = '0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic                      o_accepted;
    logic [RANK_W-1:0]         o_rank;
    logic                      o_evicted;
    logic [COUNT_W-1:0]        o_count;
    logic                      o_cfg_ready;
    int                        fail_count;
    int                        pending;

    int send_idle_pct = 0;
    int sink_stall_pct = 0;

    // Limits walked by the random phases: covers zero, one, the depth and beyond it.
    logic [CFG_W-1:0] phase_limits [PHASE_COUNT] = '{4'd3, 4'd0, 4'd15, 4'd1,
                                                     4'd8, 4'd5, 4'd2, 4'd11};

    always #5 i_clk = ~i_clk;

    top_k_score_insert_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_new    (i_start_new),
        .i_score        (i_score),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_accepted     (o_accepted),
        .o_rank         (o_rank),
        .o_evicted      (o_evicted),
        .o_count        (o_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_max_kept (i_cfg_max_kept)
    );

    top_k_score_insert_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_start_new    (i_start_new),
        .i_score        (i_score),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_accepted     (o_accepted),
        .i_rank         (o_rank),
        .i_evicted      (o_evicted),
        .i_count        (o_count),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_max_kept (i_cfg_max_kept),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Result sink: stall at the current rate, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic void apply_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                sink_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct  = HEAVY_IDLE_PCT;
                sink_stall_pct = 0;
            end
            IDLE_SINK: begin
                send_idle_pct  = 0;
                sink_stall_pct = HEAVY_IDLE_PCT;
            end
            default: begin
                send_idle_pct  = BOTH_IDLE_PCT;
                sink_stall_pct = BOTH_IDLE_PCT;
            end
        endcase
    endfunction

    // Offer one candidate beat and hold it until the block takes it.
    // Entered and left on a rising edge.
    task automatic push_candidate(input logic sn, input logic signed [SCORE_W-1:0] sc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_start_new <= sn;
        i_score     <= sc;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected result has come back.
    // Sample the checker on the falling edge so its per-edge update has settled.
    task automatic drain_results;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Write max_kept; only called with the list idle.
    task automatic write_limit(input logic [CFG_W-1:0] lim);
        i_cfg_valid    <= 1'b1;
        i_cfg_max_kept <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mix of score shapes: many near-equal values so ties and the equal-to-lowest
    // rejection come up often, plus the extremes and fully random words.
    function automatic logic signed [SCORE_W-1:0] draw_score;
        logic signed [SCORE_W-1:0] sc;
        case ($urandom_range(9))
            0: sc = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1, 2, 3, 4: sc = $signed($urandom_range(16)) - 8;
            5: sc = ($signed($urandom_range(16)) - 8) <<< 16;
            default: sc = $urandom;
        endcase
        return sc;
    endfunction

    initial begin
        apply_idle_mode(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill an empty list with the extremes and ties at the reset limit.
        push_candidate(1'b1, 32'sh0000_0000);
        push_candidate(1'b0, 32'sh7FFF_FFFF);
        push_candidate(1'b0, 32'sh8000_0000);
        push_candidate(1'b0, 32'sh0000_0000);
        push_candidate(1'b0, 32'sh0001_0000);
        push_candidate(1'b0, 32'shFFFF_0000);
        push_candidate(1'b0, 32'shFFFF_FFFF);
        push_candidate(1'b0, 32'sh0000_0001);
        // full list: equal to lowest is refused, just above it evicts, tie at the head
        push_candidate(1'b0, 32'sh8000_0000);
        push_candidate(1'b0, 32'sh8000_0001);
        push_candidate(1'b0, 32'sh7FFF_FFFF);
        // fresh list, then a few entries before shrinking the limit
        push_candidate(1'b1, 32'sh8000_0000);
        push_candidate(1'b0, 32'sh0000_0005);
        push_candidate(1'b0, -32'sd5);
        push_candidate(1'b0, 32'sh0000_0064);
        drain_results();

        // Limit lowered below the fill level: trimmed quietly, then a new best
        // on a full two-entry list must keep the old head.
        write_limit(4'd2);
        push_candidate(1'b0, 32'sh8000_0000);
        push_candidate(1'b0, 32'sh7FFF_0000);
        drain_results();

        // Zero acts as a limit of one.
        write_limit(4'd0);
        push_candidate(1'b0, 32'sh1234_5678);
        push_candidate(1'b0, 32'shEDCB_A987);
        drain_results();

        // Above the depth acts as the depth.
        write_limit(4'd15);
        push_candidate(1'b0, 32'sh5555_5555);
        push_candidate(1'b0, 32'shAAAA_AAAA);
        push_candidate(1'b1, 32'shFFFF_FFFF);
        drain_results();

        // Random phases: one limit and one idle shape each. Mostly runs on a
        // growing list with an occasional restart.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_limit(phase_limits[p]);
            apply_idle_mode(t_idle_mode'(p % 4));
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_candidate($urandom_range(19) == 0, draw_score());
            drain_results();
        end

        // Let any trailing activity settle before the verdict.
        apply_idle_mode(IDLE_NONE);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
